// File: hw/rtl/utf8cp_pkg.sv
package utf8cp_pkg;

    // byte class limits
    localparam logic [7:0] LeadMin2   = 8'hC2;
    localparam logic [7:0] LeadMin3   = 8'hE0;
    localparam logic [7:0] LeadMin4   = 8'hF0;
    localparam logic [7:0] LeadMax4   = 8'hF4;
    localparam logic [7:0] Lead4Limit = 8'hF5;
    localparam logic [7:0] E0MaxLow   = 8'h9F;
    localparam logic [7:0] F0MaxLow   = 8'h8F;
    localparam logic [7:0] F4MinHigh  = 8'h90;

    // input op codes
    localparam logic OpData = 1'b0;
    localparam logic OpEnd  = 1'b1;

    localparam int QueueDepth = 2;

    // one queued job: fallback bytes first, then an optional final result
    typedef struct packed {
        logic [1:0]      fb_count;
        logic [2:0][7:0] fb_bytes;
        logic            has_final;
        logic [20:0]     codepoint;
        logic [2:0]      source_bytes;
        logic            fell_back;
        logic            end_marker;
    } job_t;

    // windows-1252 upper half, indexed by the low 7 bits of the byte
    function automatic logic [20:0] cp1252(input logic [6:0] idx);
        logic [15:0] v;
        if (idx[6:5] != 2'b00) begin
            v = {8'h00, 1'b1, idx};
        end else begin
            case (idx[4:0])
                5'd0:  v = 16'h20AC;
                5'd1:  v = 16'h0081;
                5'd2:  v = 16'h201A;
                5'd3:  v = 16'h0192;
                5'd4:  v = 16'h201E;
                5'd5:  v = 16'h2026;
                5'd6:  v = 16'h2020;
                5'd7:  v = 16'h2021;
                5'd8:  v = 16'h02C6;
                5'd9:  v = 16'h2030;
                5'd10: v = 16'h0160;
                5'd11: v = 16'h2039;
                5'd12: v = 16'h0152;
                5'd13: v = 16'h008D;
                5'd14: v = 16'h017D;
                5'd15: v = 16'h008F;
                5'd16: v = 16'h0090;
                5'd17: v = 16'h2018;
                5'd18: v = 16'h2019;
                5'd19: v = 16'h201C;
                5'd20: v = 16'h201D;
                5'd21: v = 16'h2022;
                5'd22: v = 16'h2013;
                5'd23: v = 16'h2014;
                5'd24: v = 16'h02DC;
                5'd25: v = 16'h2122;
                5'd26: v = 16'h0161;
                5'd27: v = 16'h203A;
                5'd28: v = 16'h0153;
                5'd29: v = 16'h009D;
                5'd30: v = 16'h017E;
                5'd31: v = 16'h0178;
                default: v = 16'h0000;
            endcase
        end
        return {5'b00000, v};
    endfunction

endpackage

// File: hw/rtl/utf8_decoder_cp1252_fallback_unit.sv
// channel | handshake          | payload
// --------+--------------------+---------------------------------------------------
// input   | s_valid / s_ready  | s_op, s_byte_value
// result  | m_valid / m_ready  | m_codepoint, m_source_bytes, m_fell_back,
//         |                    | m_end_marker, m_last
//
// one input byte per cycle while the queue is not full; a request giving up to one
// result sustains that rate, and one giving n results (n up to 4) gets one result per
// cycle from the back end, while m_ready is high; the two-entry job queue absorbs the
// burst; a job is registered in the job queue, and its results in the output register
// synchronous active-low reset clears sequence state, queue and output valid
// s_ready drops only when the job queue is full, independent of m_ready in that cycle
module utf8_decoder_cp1252_fallback_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_byte_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [20:0] m_codepoint,
    output logic [2:0]  m_source_bytes,
    output logic        m_fell_back,
    output logic        m_end_marker,
    output logic        m_last
);

    logic             push;
    utf8cp_pkg::job_t push_job;
    logic             pop;
    logic             head_valid;
    utf8cp_pkg::job_t head_job;

    // front: sequence tracking and job building
    utf8cp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .op         (s_op),
        .byte_value (s_byte_value),
        .push       (push),
        .job        (push_job)
    );

    // job queue between front and back
    utf8cp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .not_full   (s_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // back: result sequencing and output register
    utf8cp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_job       (head_job),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_codepoint    (m_codepoint),
        .m_source_bytes (m_source_bytes),
        .m_fell_back    (m_fell_back),
        .m_end_marker   (m_end_marker),
        .m_last         (m_last)
    );

endmodule

// File: hw/rtl/utf8cp_front.sv
module utf8cp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              op,
    input  logic [7:0]        byte_value,
    output logic              push,
    output utf8cp_pkg::job_t  job
);

    logic [2:0][7:0] pend_reg, pend_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [2:0]      len_reg, len_next;

    logic            accept;
    logic            st_open, st_lit, st_fb;
    logic [2:0]      st_len;
    logic            follow_ok;
    logic            start_path;
    logic [20:0]     dec_cp;

    assign accept = in_valid && in_ready;

    // start-byte classification
    always_comb begin
        st_lit  = (byte_value[7] == 1'b0);
        st_open = (byte_value >= utf8cp_pkg::LeadMin2) && (byte_value < utf8cp_pkg::Lead4Limit);
        st_fb   = !st_lit && !st_open;
        if (byte_value < utf8cp_pkg::LeadMin3) begin
            st_len = 3'd2;
        end else if (byte_value < utf8cp_pkg::LeadMin4) begin
            st_len = 3'd3;
        end else begin
            st_len = 3'd4;
        end
    end

    // continuation byte check, with the second-byte range limits
    always_comb begin
        follow_ok = (byte_value[7:6] == 2'b10);
        if (cnt_reg == 2'd1) begin
            if (pend_reg[0] == utf8cp_pkg::LeadMin3 && byte_value <= utf8cp_pkg::E0MaxLow) begin
                follow_ok = 1'b0;
            end
            if (pend_reg[0] == utf8cp_pkg::LeadMin4 && byte_value <= utf8cp_pkg::F0MaxLow) begin
                follow_ok = 1'b0;
            end
            if (pend_reg[0] == utf8cp_pkg::LeadMax4 && byte_value >= utf8cp_pkg::F4MinHigh) begin
                follow_ok = 1'b0;
            end
        end
    end

    // codepoint assembly from payload bits of a complete sequence
    always_comb begin
        case (len_reg)
            3'd2:    dec_cp = {10'd0, pend_reg[0][4:0], byte_value[5:0]};
            3'd3:    dec_cp = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], byte_value[5:0]};
            3'd4:    dec_cp = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0],
                               byte_value[5:0]};
            default: dec_cp = 21'd0;
        endcase
    end

    // job building and sequence state update
    always_comb begin
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        job       = '0;
        start_path = 1'b0;
        if (op == utf8cp_pkg::OpEnd) begin
            job.fb_count   = cnt_reg;
            job.fb_bytes   = pend_reg;
            job.has_final  = 1'b1;
            job.end_marker = 1'b1;
            cnt_next       = 2'd0;
            len_next       = 3'd0;
        end else if (len_reg == 3'd0 || cnt_reg == 2'd0) begin
            start_path = 1'b1;
        end else if (!follow_ok) begin
            job.fb_count = cnt_reg;
            job.fb_bytes = pend_reg;
            start_path   = 1'b1;
        end else if (({1'b0, cnt_reg} + 3'd1) < len_reg) begin
            pend_next[cnt_reg] = byte_value;
            cnt_next           = cnt_reg + 2'd1;
        end else begin
            job.has_final    = 1'b1;
            job.codepoint    = dec_cp;
            job.source_bytes = len_reg;
            cnt_next         = 2'd0;
            len_next         = 3'd0;
        end
        // the byte taken as a new start
        if (start_path) begin
            cnt_next = 2'd0;
            len_next = 3'd0;
            if (st_lit) begin
                job.has_final    = 1'b1;
                job.codepoint    = {13'd0, byte_value};
                job.source_bytes = 3'd1;
            end else if (st_fb) begin
                job.has_final    = 1'b1;
                job.codepoint    = utf8cp_pkg::cp1252(byte_value[6:0]);
                job.source_bytes = 3'd1;
                job.fell_back    = 1'b1;
            end else begin
                pend_next[0] = byte_value;
                cnt_next     = 2'd1;
                len_next     = st_len;
            end
        end
    end

    assign push = accept && (job.has_final || (job.fb_count != 2'd0));

    // sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            len_reg <= 3'd0;
        end else if (accept) begin
            cnt_reg <= cnt_next;
            len_reg <= len_next;
        end
    end

    // held bytes
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= pend_next;
        end
    end

endmodule

// File: hw/rtl/utf8cp_queue.sv
module utf8cp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  utf8cp_pkg::job_t  push_job,
    output logic              not_full,
    input  logic              pop,
    output logic              head_valid,
    output utf8cp_pkg::job_t  head_job
);

    localparam int PtrW = $clog2(utf8cp_pkg::QueueDepth);
    localparam int CntW = $clog2(utf8cp_pkg::QueueDepth + 1);

    utf8cp_pkg::job_t         mem_reg [utf8cp_pkg::QueueDepth];
    logic [PtrW-1:0]          wr_reg, wr_next;
    logic [PtrW-1:0]          rd_reg, rd_next;
    logic [CntW-1:0]          cnt_reg, cnt_next;

    assign not_full   = (cnt_reg != CntW'(utf8cp_pkg::QueueDepth));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem_reg[rd_reg];

    // pointer and fill count update
    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PtrW'(utf8cp_pkg::QueueDepth - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == PtrW'(utf8cp_pkg::QueueDepth - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

// File: hw/rtl/utf8cp_back.sv
module utf8cp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  utf8cp_pkg::job_t  head_job,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [20:0]       m_codepoint,
    output logic [2:0]        m_source_bytes,
    output logic              m_fell_back,
    output logic              m_end_marker,
    output logic              m_last
);

    logic [1:0]  idx_reg, idx_next;
    logic        m_valid_reg;
    logic [20:0] cp_reg;
    logic [2:0]  src_reg;
    logic        fb_reg, em_reg, last_reg;

    logic        advance;
    logic [2:0]  total;
    logic        is_fb;
    logic        is_last;
    logic [7:0]  fb_byte;
    logic [20:0] cur_cp;
    logic [2:0]  cur_src;
    logic        cur_fb, cur_em;

    assign advance = head_valid && (!m_valid_reg || m_ready);
    assign total   = {1'b0, head_job.fb_count} + {2'b00, head_job.has_final};
    assign is_fb   = (idx_reg < head_job.fb_count);
    assign is_last = (({1'b0, idx_reg} + 3'd1) == total);
    assign pop     = advance && is_last;

    // pick the current result of the head job
    always_comb begin
        case (idx_reg)
            2'd0:    fb_byte = head_job.fb_bytes[0];
            2'd1:    fb_byte = head_job.fb_bytes[1];
            2'd2:    fb_byte = head_job.fb_bytes[2];
            default: fb_byte = 8'h00;
        endcase
        if (is_fb) begin
            cur_cp  = utf8cp_pkg::cp1252(fb_byte[6:0]);
            cur_src = 3'd1;
            cur_fb  = 1'b1;
            cur_em  = 1'b0;
        end else begin
            cur_cp  = head_job.codepoint;
            cur_src = head_job.source_bytes;
            cur_fb  = head_job.fell_back;
            cur_em  = head_job.end_marker;
        end
        idx_next = idx_reg;
        if (advance) begin
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (advance) begin
            cp_reg   <= cur_cp;
            src_reg  <= cur_src;
            fb_reg   <= cur_fb;
            em_reg   <= cur_em;
            last_reg <= is_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_codepoint    = cp_reg;
    assign m_source_bytes = src_reg;
    assign m_fell_back    = fb_reg;
    assign m_end_marker   = em_reg;
    assign m_last         = last_reg;

endmodule
